### rtl/cbm_pkg.sv
// ----------------------------------------------------------------------------
// cbm_pkg - shared types and constants for the cartridge bank mapper
// Beat layouts, operation codes and write-decode constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cbm_pkg;

  // Operation kind carried in in_tuser
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_PRG   = 2'd1,
    OP_CHR   = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // Field widths
  localparam int unsigned ADDR_W   = 16;
  localparam int unsigned DATA_W   = 8;
  localparam int unsigned OFFS_W   = 18;
  localparam int unsigned MIRR_W   = 2;
  localparam int unsigned PRGB_W   = 2;
  localparam int unsigned CHRB_W   = 8;
  localparam int unsigned CHR_NUM  = 8;
  localparam int unsigned CHRI_W   = 3;

  // Stream widths (padded to whole bytes)
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 24;

  // Write decode
  localparam logic [ADDR_W-1:0] DEC_MASK = 16'hF00C;
  localparam logic [ADDR_W-1:0] DEC_IRQ  = 16'hF008;
  localparam logic [3:0] GRP_PRG   = 4'h9;
  localparam logic [3:0] GRP_FIXED = 4'hC;
  localparam logic [3:0] GRP_CHR01 = 4'hD;
  localparam logic [3:0] GRP_CHR23 = 4'hA;
  localparam logic [3:0] GRP_CHR45 = 4'hB;
  localparam logic [3:0] GRP_CHR67 = 4'hE;
  localparam logic [3:0] GRP_IRQ   = 4'hF;

  localparam logic [CHRI_W-1:0] CHR_BASE01 = 3'd0;
  localparam logic [CHRI_W-1:0] CHR_BASE23 = 3'd2;
  localparam logic [CHRI_W-1:0] CHR_BASE45 = 3'd4;
  localparam logic [CHRI_W-1:0] CHR_BASE67 = 3'd6;

  // One input item
  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;
  } item_t;

  // One result item
  typedef struct packed {
    logic [OFFS_W-1:0] rom_offset;
    logic [MIRR_W-1:0] mirror_mode;
    logic              write_ignored;
  } result_t;

endpackage

`default_nettype wire

### rtl/cartridge_bank_mapper_unit.sv
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_unit - bank-switching cartridge mapper
//
// Slave channel (in_*): one beat per bus operation. in_tuser selects the
// operation: register write, CPU PRG read translate, PPU pattern translate.
// Master channel (out_*): exactly one result beat per input beat, in order,
// carrying the ROM byte offset, the current mirroring and the ignored-write
// flag.
// Pipeline: the input register loads at the accepting edge, and the result
// register loads once it is empty or draining. Throughput: one beat per
// cycle while out_tready stays high; a write takes effect for the very next
// beat.
// Reset (rst_n low, synchronous) clears both stages, the PRG bank, the PRG
// mode bit, the mirroring and all eight CHR bank registers.
// Stall: while out_tready is low the result register holds; the input
// register still accepts one beat, then in_tready drops until the result
// drains. Nothing is dropped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cartridge_bank_mapper_unit
  import cbm_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // slave channel
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // [15:0] address, [23:16] write_data
  input  wire logic [1:0]             in_tuser,   // [1:0] mode
  // master channel
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // [17:0] rom_offset, [19:18] mirror_mode,
                                                  // [23:20] zero
  output logic                        out_tuser   // [0] write_ignored
);

  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    advance;
  result_t result;
  result_t out_result;

  // Unpack the slave beat
  assign in_item.op         = op_t'(in_tuser);
  assign in_item.address    = in_tdata[15:0];
  assign in_item.write_data = in_tdata[23:16];

  cbm_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  cbm_xlate u_xlate (
    .clk    (clk),
    .rst_n  (rst_n),
    .commit (advance),
    .item   (item),
    .result (result)
  );

  cbm_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .result     (result),
    .advance    (advance),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_result (out_result)
  );

  // Pack the master beat
  assign out_tdata = {4'h0, out_result.mirror_mode, out_result.rom_offset};
  assign out_tuser = out_result.write_ignored;

endmodule

`default_nettype wire

### rtl/cbm_in_stage.sv
// ----------------------------------------------------------------------------
// cbm_in_stage - input register
// Captures one beat from the slave channel and holds it until it advances.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cbm_in_stage
  import cbm_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire item_t in_item,
  input  wire logic  advance,   // held item moves to the result stage
  output logic       item_valid,
  output item_t      item
);

  logic  vld_r, vld_nxt;
  item_t item_r;

  // Free slot, or the held item leaves this cycle
  assign in_ready = !vld_r || advance;

  always_comb begin
    vld_nxt = vld_r;
    if (in_ready) begin
      vld_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

  assign item_valid = vld_r;
  assign item       = item_r;

endmodule

`default_nettype wire

### rtl/cbm_xlate.sv
// ----------------------------------------------------------------------------
// cbm_xlate - mapper state and address translation
// Holds the bank registers, decodes writes and translates PRG/CHR addresses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cbm_xlate
  import cbm_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  commit,    // item is taken into the result register
  input  wire item_t item,
  output result_t    result
);

  logic [PRGB_W-1:0] prg_bank_r, prg_bank_nxt;
  logic              fixed_r, fixed_nxt;
  logic [MIRR_W-1:0] mirror_r, mirror_nxt;
  logic [CHRB_W-1:0] chr_r [CHR_NUM];

  logic [ADDR_W-1:0] dec;
  logic [1:0]        sub;
  logic [CHRI_W-1:0] chr_base;
  logic [CHRI_W-1:0] chr_widx;
  logic              chr_we;
  logic              ignored;
  logic [14:0]       prg_a;
  logic [16:0]       prg_off;
  logic [CHRB_W-1:0] chr_bank;

  assign dec      = item.address & DEC_MASK;
  assign sub      = dec[3:2];
  assign chr_widx = chr_base + {2'b00, sub[1]};

  // Write decode
  always_comb begin
    prg_bank_nxt = prg_bank_r;
    fixed_nxt    = fixed_r;
    mirror_nxt   = mirror_r;
    chr_base     = CHR_BASE01;
    chr_we       = 1'b0;
    ignored      = 1'b0;
    if (item.op == OP_WRITE) begin
      unique case (dec[15:12])
        GRP_PRG: begin
          prg_bank_nxt = item.write_data[3:2];
          if (sub == 2'd0) begin
            mirror_nxt = item.write_data[1:0];
          end
        end
        GRP_FIXED: fixed_nxt = item.write_data[0];
        GRP_CHR01: begin
          chr_base = CHR_BASE01;
          chr_we   = 1'b1;
        end
        GRP_CHR23: begin
          chr_base = CHR_BASE23;
          chr_we   = 1'b1;
        end
        GRP_CHR45: begin
          chr_base = CHR_BASE45;
          chr_we   = 1'b1;
        end
        GRP_CHR67: begin
          chr_base = CHR_BASE67;
          chr_we   = 1'b1;
        end
        // interrupt control is accepted but has no effect
        GRP_IRQ: ignored = (dec != DEC_IRQ);
        default: ignored = 1'b1;
      endcase
    end
  end

  // State update as the item commits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_bank_r <= '0;
      fixed_r    <= 1'b0;
      mirror_r   <= '0;
      for (int i = 0; i < CHR_NUM; i++) begin
        chr_r[i] <= '0;
      end
    end else if (commit) begin
      prg_bank_r <= prg_bank_nxt;
      fixed_r    <= fixed_nxt;
      mirror_r   <= mirror_nxt;
      if (chr_we) begin
        if (sub[0]) begin
          chr_r[chr_widx] <= {item.write_data[3:0], chr_r[chr_widx][3:0]};
        end else begin
          chr_r[chr_widx] <= {chr_r[chr_widx][7:4], item.write_data[3:0]};
        end
      end
    end
  end

  // PRG: 32 KB window; unless fixed, 0xC000-0xDFFF -> bank's first 8 KB
  assign prg_a = item.address[14:0];
  always_comb begin
    if (!fixed_r && prg_a[14:13] == 2'b10) begin
      prg_off = {prg_bank_r, 2'b00, prg_a[12:0]};
    end else begin
      prg_off = {prg_bank_r, prg_a};
    end
  end

  // CHR: eight 1 KB banks
  assign chr_bank = chr_r[item.address[12:10]];

  // Result after this step
  always_comb begin
    result.mirror_mode   = mirror_nxt;
    result.write_ignored = ignored;
    unique case (item.op)
      OP_PRG:  result.rom_offset = {1'b0, prg_off};
      OP_CHR:  result.rom_offset = {chr_bank, item.address[9:0]};
      default: result.rom_offset = '0;
    endcase
  end

endmodule

`default_nettype wire

### rtl/cbm_out_stage.sv
// ----------------------------------------------------------------------------
// cbm_out_stage - result register
// Holds one result beat for the master channel; refills when it drains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cbm_out_stage
  import cbm_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    item_valid,
  input  wire result_t result,
  output logic         advance,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      out_result
);

  logic    vld_r, vld_nxt;
  result_t res_r;

  // Take a new result when empty or draining
  assign advance = item_valid && (!vld_r || out_ready);

  always_comb begin
    vld_nxt = vld_r;
    if (advance) begin
      vld_nxt = 1'b1;
    end else if (out_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= result;
    end
  end

  assign out_valid  = vld_r;
  assign out_result = res_r;

endmodule

`default_nettype wire

### tb/cbm_translation_checker.sv
// ----------------------------------------------------------------------------
// cbm_translation_checker - result predictor and comparator for the mapper
// Watches both stream channels. It keeps its own copy of the mapper's bank
// registers and works out the expected result for every accepted input beat.
// It compares each accepted result beat, field by field, with the oldest
// expected result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cbm_translation_checker
  import cbm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [15:0] address, [23:16] write_data
  input  logic [1:0]             in_tuser,   // [1:0] mode
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,  // [17:0] rom_offset, [19:18] mirror_mode,
                                             // [23:20] zero
  input  logic                   out_tuser,  // [0] write_ignored
  output int                     mismatches,
  output int                     outstanding
);

  // shadow copy of the mapper's bank registers
  logic [PRGB_W-1:0] prg_bank_q;
  logic              prg_fixed_q;
  logic [MIRR_W-1:0] mirroring_q;
  logic [CHRB_W-1:0] chr_bank_q [CHR_NUM];

  result_t pending_translations [$];

  // Applies one bus operation to the shadow registers; returns its result
  function automatic result_t mapped_result(op_t op, logic [ADDR_W-1:0] addr,
                                            logic [DATA_W-1:0] data);
    result_t           r;
    logic [ADDR_W-1:0] dec;
    logic [1:0]        sub;
    logic [CHRI_W-1:0] idx;
    logic              chr_wr;
    logic [14:0]       cpu_a;
    r      = '0;
    idx    = '0;
    chr_wr = 1'b0;
    case (op)
      OP_WRITE: begin
        dec = addr & DEC_MASK;
        sub = dec[3:2];
        case (dec[15:12])
          GRP_PRG: begin
            prg_bank_q = data[3:2];
            // only the first register of the group also sets mirroring
            if (sub == 2'd0) mirroring_q = data[1:0];
          end
          GRP_FIXED: prg_fixed_q = data[0];
          GRP_CHR01: begin idx = CHR_BASE01; chr_wr = 1'b1; end
          GRP_CHR23: begin idx = CHR_BASE23; chr_wr = 1'b1; end
          GRP_CHR45: begin idx = CHR_BASE45; chr_wr = 1'b1; end
          GRP_CHR67: begin idx = CHR_BASE67; chr_wr = 1'b1; end
          // interrupt control is accepted but does nothing
          GRP_IRQ:   r.write_ignored = (dec != DEC_IRQ);
          default:   r.write_ignored = 1'b1;
        endcase
        if (chr_wr) begin
          idx = idx + CHRI_W'(sub[1]);
          if (!sub[0]) chr_bank_q[idx][3:0] = data[3:0];
          else         chr_bank_q[idx][7:4] = data[3:0];
        end
      end
      OP_PRG: begin
        // bit 15 is dropped; unless fixed, 0xC000-0xDFFF folds onto the bank's first 8 KB
        cpu_a = addr[14:0];
        if (!prg_fixed_q && cpu_a[14:13] == 2'b10)
          r.rom_offset = {1'b0, prg_bank_q, 2'b00, cpu_a[12:0]};
        else
          r.rom_offset = {1'b0, prg_bank_q, cpu_a};
      end
      OP_CHR: r.rom_offset = {chr_bank_q[addr[12:10]], addr[9:0]};
      default: ;
    endcase
    r.mirror_mode = mirroring_q;
    return r;
  endfunction

  function automatic void report_field(string name, logic [OFFS_W-1:0] exp_v,
                                       logic [OFFS_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name,
               exp_v, act_v);
      mismatches++;
    end
  endfunction

  // result side first, so a beat can never match an expectation from the same edge
  always @(posedge clk) begin
    result_t exp_r;
    if (!rst_n) begin
      prg_bank_q  = '0;
      prg_fixed_q = 1'b0;
      mirroring_q = '0;
      foreach (chr_bank_q[i]) chr_bank_q[i] = '0;
      pending_translations.delete();
      outstanding = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (pending_translations.size() == 0) begin
          $display("%0t ns: unexpected result beat, expected none, actual data 0x%0h user %0b",
                   $time, out_tdata, out_tuser);
          mismatches++;
        end else begin
          exp_r = pending_translations.pop_front();
          report_field("rom_offset", exp_r.rom_offset, out_tdata[17:0]);
          report_field("mirror_mode", OFFS_W'(exp_r.mirror_mode), OFFS_W'(out_tdata[19:18]));
          report_field("write_ignored", OFFS_W'(exp_r.write_ignored), OFFS_W'(out_tuser));
          report_field("tdata padding", '0, OFFS_W'(out_tdata[23:20]));
        end
      end
      if (in_tvalid && in_tready)
        pending_translations.push_back(mapped_result(op_t'(in_tuser), in_tdata[15:0],
                                                     in_tdata[23:16]));
      outstanding = pending_translations.size();
    end
  end

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - stimulus and verdict for the cartridge bank mapper
// A directed pass covers the register groups, the folded PRG window, the
// interrupt control write, unmatched writes and the unused mode. A random
// pass follows, with mostly well-formed register writes mixed with PRG and
// CHR translations. The sender works in bursts and the receiver stalls in
// several styles. The checker predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import cbm_pkg::*;

  typedef enum int {RX_FREE, RX_RANDOM, RX_PERIODIC, RX_HEAVY} rx_style_t;

  localparam int RANDOM_PHASE_BEATS = 475;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [1:0]             in_tuser   = OP_NONE;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  int                     mismatches;
  int                     outstanding;

  rx_style_t   rx_style   = RX_FREE;
  int unsigned rx_cycle   = 0;
  int unsigned burst_left = 0;
  int unsigned max_gap    = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  cartridge_bank_mapper_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  cbm_translation_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // receiver backpressure
  always @(negedge clk) begin
    rx_cycle <= rx_cycle + 1;
    case (rx_style)
      RX_FREE:     out_tready <= 1'b1;
      RX_RANDOM:   out_tready <= ($urandom_range(0, 99) < 70);
      RX_PERIODIC: out_tready <= ((rx_cycle % 7) < 4);
      default:     out_tready <= ($urandom_range(0, 99) < 25);
    endcase
  end

  // register address with the decode bits set and the rest zero
  function automatic logic [ADDR_W-1:0] reg_addr(logic [3:0] grp, logic [1:0] sub);
    return {grp, 8'h00, sub, 2'b00};
  endfunction

  // one beat, inserting a random gap when the current burst is used up
  task automatic send_beat(op_t op, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, max_gap);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {data, addr};
    in_tuser  <= op;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
  endtask

  task automatic send_random_beat();
    int unsigned       pick;
    op_t               op;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    pick = $urandom_range(0, 99);
    addr = ADDR_W'($urandom_range(0, 65535));
    data = DATA_W'($urandom_range(0, 255));
    if (pick < 45) begin
      op = OP_WRITE;
      // mostly hit a register group, with random bits outside the decode mask
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 6))
          0:       addr[15:12] = GRP_PRG;
          1:       addr[15:12] = GRP_FIXED;
          2:       addr[15:12] = GRP_CHR01;
          3:       addr[15:12] = GRP_CHR23;
          4:       addr[15:12] = GRP_CHR45;
          5:       addr[15:12] = GRP_CHR67;
          default: addr[15:12] = GRP_IRQ;
        endcase
      end
    end else if (pick < 70) op = OP_PRG;
    else if (pick < 95)     op = OP_CHR;
    else                    op = OP_NONE;
    send_beat(op, addr, data);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed pass
    rx_style = RX_RANDOM;
    send_beat(OP_PRG,   16'h8000, 8'h00);
    send_beat(OP_PRG,   16'hC000, 8'h00);                    // folded window at reset
    send_beat(OP_PRG,   16'hFFFF, 8'hFF);
    send_beat(OP_WRITE, reg_addr(GRP_PRG, 2'd0), 8'hFF);     // bank 3, single screen high
    send_beat(OP_PRG,   16'hC123, 8'h00);
    send_beat(OP_PRG,   16'h4567, 8'h00);                    // CPU read below 0x8000
    send_beat(OP_WRITE, reg_addr(GRP_PRG, 2'd1), 8'h0B);     // bank only, mirroring kept
    send_beat(OP_WRITE, reg_addr(GRP_FIXED, 2'd2), 8'hFF);
    send_beat(OP_PRG,   16'hDFFF, 8'h00);
    send_beat(OP_WRITE, reg_addr(GRP_FIXED, 2'd3), 8'hFE);
    send_beat(OP_PRG,   16'hDFFF, 8'h00);
    send_beat(OP_WRITE, reg_addr(GRP_CHR01, 2'd0), 8'hFF);
    send_beat(OP_WRITE, reg_addr(GRP_CHR01, 2'd1), 8'hFA);
    send_beat(OP_WRITE, reg_addr(GRP_CHR67, 2'd3), 8'h0F);
    send_beat(OP_WRITE, reg_addr(GRP_CHR23, 2'd2), 8'h35);
    send_beat(OP_WRITE, reg_addr(GRP_CHR45, 2'd1) | 16'h0FF3, 8'hFF);
    send_beat(OP_CHR,   16'h0000, 8'h00);
    send_beat(OP_CHR,   16'hFFFF, 8'hFF);                    // PPU bits 15..13 dropped
    send_beat(OP_CHR,   16'h0DFF, 8'h00);
    send_beat(OP_WRITE, reg_addr(GRP_IRQ, 2'd2), 8'hFF);     // interrupt control write
    send_beat(OP_WRITE, reg_addr(GRP_IRQ, 2'd0), 8'h00);     // unmatched
    send_beat(OP_WRITE, 16'h7FFF, 8'hAA);                    // below 0x8000
    send_beat(OP_WRITE, 16'h8000, 8'h55);
    send_beat(OP_NONE,  16'hFFFF, 8'hFF);                    // unused mode
    send_beat(OP_WRITE, reg_addr(GRP_PRG, 2'd0), 8'h00);

    // random pass, one idling style per phase
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin rx_style = RX_FREE;     max_gap = 0; end
        1:       begin rx_style = RX_RANDOM;   max_gap = 4; end
        2:       begin rx_style = RX_PERIODIC; max_gap = 2; end
        default: begin rx_style = RX_HEAVY;    max_gap = 6; end
      endcase
      repeat (RANDOM_PHASE_BEATS) send_random_beat();
    end

    // drain
    @(negedge clk);
    in_tvalid <= 1'b0;
    rx_style = RX_RANDOM;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

### cartridge_bank_mapper_unit.f
rtl/cbm_pkg.sv
rtl/cbm_in_stage.sv
rtl/cbm_xlate.sv
rtl/cbm_out_stage.sv
rtl/cartridge_bank_mapper_unit.sv
tb/cbm_translation_checker.sv
tb/tb_top.sv
